/* hdl/jst_pkg.sv */
// Shared types, constants and helpers for the JSON stream tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none
package jst_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int DEPTH_W   = 7;
    localparam int MAXRES    = 4;
    localparam int CNT_W     = $clog2(MAXRES + 1);
    localparam int POS_W     = $clog2(MAXRES);

    localparam logic [1:0] FN_DATA    = 2'd0;
    localparam logic [1:0] FN_END     = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;

    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_EVENT = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;

    localparam logic [3:0] TK_NULL      = 4'd0;
    localparam logic [3:0] TK_STRING    = 4'd3;
    localparam logic [3:0] TK_NUMBER    = 4'd4;
    localparam logic [3:0] TK_ARR_BEGIN = 4'd5;
    localparam logic [3:0] TK_ARR_END   = 4'd6;
    localparam logic [3:0] TK_OBJ_BEGIN = 4'd7;
    localparam logic [3:0] TK_OBJ_END   = 4'd8;
    localparam logic [3:0] TK_DONE      = 4'd9;

    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_EOF      = 4'd0;
    localparam logic [3:0] E_BYTE     = 4'd1;
    localparam logic [3:0] E_LITERAL  = 4'd2;
    localparam logic [3:0] E_UNTERM   = 4'd3;
    localparam logic [3:0] E_CTRL     = 4'd4;
    localparam logic [3:0] E_ESCAPE   = 4'd5;
    localparam logic [3:0] E_HEX      = 4'd6;
    localparam logic [3:0] E_SURR     = 4'd7;
    localparam logic [3:0] E_UTF8     = 4'd8;
    localparam logic [3:0] E_NUMBER   = 4'd9;
    localparam logic [3:0] E_OBJECT   = 4'd10;
    localparam logic [3:0] E_OVERFLOW = 4'd11;

    localparam logic [4:0] M_TOP       = 5'd0;
    localparam logic [4:0] M_ARR_FIRST = 5'd1;
    localparam logic [4:0] M_VALUE     = 5'd2;
    localparam logic [4:0] M_AFTER     = 5'd3;
    localparam logic [4:0] M_OBJ_FIRST = 5'd4;
    localparam logic [4:0] M_KEY       = 5'd5;
    localparam logic [4:0] M_COLON     = 5'd6;
    localparam logic [4:0] M_LIT       = 5'd7;
    localparam logic [4:0] M_N_MINUS   = 5'd8;
    localparam logic [4:0] M_N_ZERO    = 5'd9;
    localparam logic [4:0] M_N_INT     = 5'd10;
    localparam logic [4:0] M_N_FRAC0   = 5'd11;
    localparam logic [4:0] M_N_FRAC    = 5'd12;
    localparam logic [4:0] M_N_EXP0    = 5'd13;
    localparam logic [4:0] M_N_EXPS    = 5'd14;
    localparam logic [4:0] M_N_EXP     = 5'd15;
    localparam logic [4:0] M_STR       = 5'd16;
    localparam logic [4:0] M_KEY_BIT   = 5'd8;

    localparam logic [2:0] S_PLAIN = 3'd0;
    localparam logic [2:0] S_ESC   = 3'd1;
    localparam logic [2:0] S_HEXH  = 3'd2;
    localparam logic [2:0] S_BSL   = 3'd3;
    localparam logic [2:0] S_U     = 3'd4;
    localparam logic [2:0] S_HEXL  = 3'd5;
    localparam logic [2:0] S_UTF8  = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         token;
        logic [7:0]         byte_value;
        logic [DEPTH_W-1:0] depth;
        logic [3:0]         error_code;
    } t_res;

    typedef t_res [MAXRES-1:0] t_res_arr;

    typedef struct packed {
        logic [4:0]       mode;
        logic [LVL_W-1:0] lvl;
        logic [15:0]      acc;
        logic [9:0]       hsur;
        logic [23:0]      hold;
        logic [1:0]       left;
        logic [31:0]      line;
        logic             seen;
        logic             err;
    } t_state;

    function automatic logic [7:0] lit_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:  r = "u";
            4'd1:  r = "l";
            4'd2:  r = "l";
            4'd4:  r = "a";
            4'd5:  r = "l";
            4'd6:  r = "s";
            4'd7:  r = "e";
            4'd9:  r = "r";
            4'd10: r = "u";
            4'd11: r = "e";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] r;
        if (b < 8'h80) r = 3'd1;
        else if (b >= 8'hC2 && b <= 8'hDF) r = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF) r = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4) r = 3'd4;
        else r = 3'd0;
        return r;
    endfunction

    // bit 4 flags a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
        else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
        else r = 5'd0;
        return r;
    endfunction

    function automatic void emit(inout t_res_arr r, inout logic [CNT_W-1:0] n,
                                 input logic [1:0] kind, input logic [3:0] tok,
                                 input logic [7:0] b, input logic [LVL_W-1:0] lvl,
                                 input logic [3:0] code);
        if (n < CNT_W'(MAXRES)) begin
            r[n[POS_W-1:0]].kind       = kind;
            r[n[POS_W-1:0]].token      = tok;
            r[n[POS_W-1:0]].byte_value = b;
            r[n[POS_W-1:0]].depth      = DEPTH_W'(lvl);
            r[n[POS_W-1:0]].error_code = code;
            n = n + 1'b1;
        end
    endfunction

    function automatic void emit_cp(inout t_res_arr r, inout logic [CNT_W-1:0] n,
                                    input logic [20:0] cp, input logic [LVL_W-1:0] lvl);
        if (cp < 21'h80) begin
            emit(r, n, K_BYTE, TK_STRING, cp[7:0], lvl, E_NONE);
        end else if (cp < 21'h800) begin
            emit(r, n, K_BYTE, TK_STRING, {3'b110, cp[10:6]}, lvl, E_NONE);
            emit(r, n, K_BYTE, TK_STRING, {2'b10, cp[5:0]}, lvl, E_NONE);
        end else if (cp < 21'h10000) begin
            emit(r, n, K_BYTE, TK_STRING, {4'b1110, cp[15:12]}, lvl, E_NONE);
            emit(r, n, K_BYTE, TK_STRING, {2'b10, cp[11:6]}, lvl, E_NONE);
            emit(r, n, K_BYTE, TK_STRING, {2'b10, cp[5:0]}, lvl, E_NONE);
        end else begin
            emit(r, n, K_BYTE, TK_STRING, {5'b11110, cp[20:18]}, lvl, E_NONE);
            emit(r, n, K_BYTE, TK_STRING, {2'b10, cp[17:12]}, lvl, E_NONE);
            emit(r, n, K_BYTE, TK_STRING, {2'b10, cp[11:6]}, lvl, E_NONE);
            emit(r, n, K_BYTE, TK_STRING, {2'b10, cp[5:0]}, lvl, E_NONE);
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/jst_step.sv */
// Next-state and result logic for one word of the tokenizer.
// Depends on jst_pkg.
`default_nettype none
module jst_step (
    input  var jst_pkg::t_state               i_st,
    input  var logic [jst_pkg::MAX_DEPTH-1:0] i_stk,
    input  var logic                          i_streaming,
    input  var logic [1:0]                    i_func,
    input  var logic [7:0]                    i_data_byte,
    output jst_pkg::t_state                   o_st,
    output logic [jst_pkg::MAX_DEPTH-1:0]     o_stk,
    output jst_pkg::t_res_arr                 o_res,
    output logic [jst_pkg::CNT_W-1:0]         o_cnt
);
    import jst_pkg::*;

    t_state           s;
    logic [MAX_DEPTH-1:0] stk;
    t_res_arr         r;
    logic [CNT_W-1:0] n;
    logic [7:0]       c;
    logic             dig;
    logic             ex;
    logic             cont;
    logic [4:0]       h;
    logic [15:0]      v;
    logic [3:0]       idx;
    logic [3:0]       idx1;
    logic [2:0]       len;
    logic [2:0]       stored;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       b3;
    logic             bad;
    logic             obj;

    always_comb begin
        s = i_st;
        stk = i_stk;
        r = '0;
        n = '0;
        c = i_data_byte;
        dig = (c >= "0" && c <= "9");
        ex = (c == "e" || c == "E");
        cont = 1'b1;
        h = hex_val(c);
        v = '0;
        idx = '0;
        idx1 = '0;
        len = '0;
        stored = '0;
        lo = 8'h80;
        hi = 8'hBF;
        b1 = '0;
        b2 = '0;
        b3 = '0;
        bad = 1'b0;
        obj = 1'b0;
        unique case (i_func)
            FN_RESTART: begin
                s.mode = M_TOP;
                s.lvl = '0;
                s.acc = '0;
                s.hsur = '0;
                s.hold = '0;
                s.left = '0;
                s.seen = 1'b0;
                s.err = 1'b0;
            end
            FN_DATA: begin
                if (!i_st.err) begin
                    if (s.mode >= M_STR) begin
                        case (s.mode[2:0])
                            S_PLAIN: begin
                                if (c == "\"") begin
                                    emit(r, n, K_EVENT, TK_STRING, 8'd0, s.lvl, E_NONE);
                                    if (s.mode[3]) s.mode = M_COLON;
                                    else s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                                end else if (c == "\\") begin
                                    s.mode[2:0] = S_ESC;
                                end else if (c >= 8'h80) begin
                                    len = seq_len(c);
                                    if (len == 3'd0) begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_UTF8);
                                        s.err = 1'b1;
                                    end else begin
                                        s.hold = {16'd0, c};
                                        s.left = 2'(len - 3'd1);
                                        s.mode[2:0] = S_UTF8;
                                    end
                                end else if (c < 8'h20) begin
                                    emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_CTRL);
                                    s.err = 1'b1;
                                end else begin
                                    emit(r, n, K_BYTE, TK_STRING, c, s.lvl, E_NONE);
                                end
                            end
                            S_ESC: begin
                                case (c)
                                    "\\", "/", "\"": v = {8'd0, c};
                                    "b": v = 16'd8;
                                    "f": v = 16'd12;
                                    "n": v = 16'd10;
                                    "r": v = 16'd13;
                                    "t": v = 16'd9;
                                    default: v = 16'hFFFF;
                                endcase
                                if (c == "u") begin
                                    s.acc = '0;
                                    s.left = '0;
                                    s.mode[2:0] = S_HEXH;
                                end else if (v == 16'hFFFF) begin
                                    emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_ESCAPE);
                                    s.err = 1'b1;
                                end else begin
                                    emit(r, n, K_BYTE, TK_STRING, v[7:0], s.lvl, E_NONE);
                                    s.mode[2:0] = S_PLAIN;
                                end
                            end
                            S_HEXH, S_HEXL: begin
                                if (!h[4]) begin
                                    emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_HEX);
                                    s.err = 1'b1;
                                end else begin
                                    s.acc = {s.acc[11:0], h[3:0]};
                                    if (s.left < 2'd3) begin
                                        s.left = s.left + 2'd1;
                                    end else begin
                                        s.left = '0;
                                        v = s.acc;
                                        if (s.mode[2:0] == S_HEXH) begin
                                            if (v >= 16'hD800 && v <= 16'hDBFF) begin
                                                s.hsur = v[9:0];
                                                s.mode[2:0] = S_BSL;
                                            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                                                emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl,
                                                     E_SURR);
                                                s.err = 1'b1;
                                            end else begin
                                                emit_cp(r, n, {5'd0, v}, s.lvl);
                                                s.mode[2:0] = S_PLAIN;
                                            end
                                        end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_SURR);
                                            s.err = 1'b1;
                                        end else begin
                                            emit_cp(r, n, 21'h10000 + {1'b0, s.hsur, v[9:0]},
                                                    s.lvl);
                                            s.mode[2:0] = S_PLAIN;
                                        end
                                    end
                                end
                            end
                            S_BSL: begin
                                if (c == "\\") begin
                                    s.mode[2:0] = S_U;
                                end else begin
                                    emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_SURR);
                                    s.err = 1'b1;
                                end
                            end
                            S_U: begin
                                if (c == "u") begin
                                    s.acc = '0;
                                    s.left = '0;
                                    s.mode[2:0] = S_HEXL;
                                end else begin
                                    emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_SURR);
                                    s.err = 1'b1;
                                end
                            end
                            S_UTF8: begin
                                len = seq_len(s.hold[7:0]);
                                if (s.left > 2'd1) begin
                                    stored = len - {1'b0, s.left};
                                    if (stored == 3'd1) begin
                                        s.hold[15:8] = s.hold[15:8] | c;
                                        s.left = s.left - 2'd1;
                                    end else if (stored == 3'd2) begin
                                        s.hold[23:16] = s.hold[23:16] | c;
                                        s.left = s.left - 2'd1;
                                    end else begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_UTF8);
                                        s.err = 1'b1;
                                    end
                                end else begin
                                    b1 = (len == 3'd2) ? c : s.hold[15:8];
                                    b2 = (len == 3'd3) ? c : s.hold[23:16];
                                    b3 = c;
                                    if (s.hold[7:0] == 8'hE0) lo = 8'hA0;
                                    else if (s.hold[7:0] == 8'hED) hi = 8'h9F;
                                    else if (s.hold[7:0] == 8'hF0) lo = 8'h90;
                                    else if (s.hold[7:0] == 8'hF4) hi = 8'h8F;
                                    bad = (len < 3'd2) || b1 < lo || b1 > hi ||
                                          (len >= 3'd3 && (b2 < 8'h80 || b2 > 8'hBF)) ||
                                          (len == 3'd4 && (b3 < 8'h80 || b3 > 8'hBF));
                                    if (bad) begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_UTF8);
                                        s.err = 1'b1;
                                    end else begin
                                        emit(r, n, K_BYTE, TK_STRING, s.hold[7:0], s.lvl,
                                             E_NONE);
                                        emit(r, n, K_BYTE, TK_STRING, b1, s.lvl, E_NONE);
                                        if (len >= 3'd3)
                                            emit(r, n, K_BYTE, TK_STRING, b2, s.lvl, E_NONE);
                                        if (len == 3'd4)
                                            emit(r, n, K_BYTE, TK_STRING, b3, s.lvl, E_NONE);
                                        s.hold = '0;
                                        s.left = '0;
                                        s.mode[2:0] = S_PLAIN;
                                    end
                                end
                            end
                            default: begin
                                emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_BYTE);
                                s.err = 1'b1;
                            end
                        endcase
                    end else begin
                        if (s.mode >= M_N_MINUS) begin
                            case (s.mode)
                                M_N_MINUS: begin
                                    if (!dig) begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_BYTE);
                                        s.err = 1'b1;
                                    end else begin
                                        s.mode = (c == "0") ? M_N_ZERO : M_N_INT;
                                        emit(r, n, K_BYTE, TK_NUMBER, c, s.lvl, E_NONE);
                                    end
                                    cont = 1'b0;
                                end
                                M_N_ZERO, M_N_INT, M_N_FRAC: begin
                                    if (dig && s.mode != M_N_ZERO) begin
                                        cont = 1'b0;
                                    end else if (c == "." && s.mode != M_N_FRAC) begin
                                        s.mode = M_N_FRAC0;
                                        cont = 1'b0;
                                    end else if (ex) begin
                                        s.mode = M_N_EXP0;
                                        cont = 1'b0;
                                    end
                                    if (!cont)
                                        emit(r, n, K_BYTE, TK_NUMBER, c, s.lvl, E_NONE);
                                end
                                M_N_FRAC0, M_N_EXPS, M_N_EXP0: begin
                                    cont = 1'b0;
                                    if (s.mode == M_N_EXP0 && (c == "+" || c == "-")) begin
                                        s.mode = M_N_EXPS;
                                        emit(r, n, K_BYTE, TK_NUMBER, c, s.lvl, E_NONE);
                                    end else if (!dig) begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_NUMBER);
                                        s.err = 1'b1;
                                    end else begin
                                        s.mode = (s.mode == M_N_FRAC0) ? M_N_FRAC : M_N_EXP;
                                        emit(r, n, K_BYTE, TK_NUMBER, c, s.lvl, E_NONE);
                                    end
                                end
                                default: begin
                                    if (dig) begin
                                        cont = 1'b0;
                                        emit(r, n, K_BYTE, TK_NUMBER, c, s.lvl, E_NONE);
                                    end
                                end
                            endcase
                            if (cont) begin
                                emit(r, n, K_EVENT, TK_NUMBER, 8'd0, s.lvl, E_NONE);
                                s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                            end
                        end
                        if (cont) begin
                            if (s.mode == M_LIT) begin
                                idx = s.acc[3:0];
                                idx1 = idx + 4'd1;
                                if (idx > 4'd11 || lit_char(idx) != c) begin
                                    emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_LITERAL);
                                    s.err = 1'b1;
                                end else if (lit_char(idx1) == 8'd0) begin
                                    emit(r, n, K_EVENT, {2'd0, s.acc[5:4]}, 8'd0, s.lvl,
                                         E_NONE);
                                    s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                                end else begin
                                    s.acc = {10'd0, s.acc[5:4], idx1};
                                end
                            end else if (c == 8'd9 || c == 8'd10 || c == 8'd13 || c == " ") begin
                                if (c == 8'd10 && s.line != 32'hFFFF_FFFF)
                                    s.line = s.line + 32'd1;
                            end else begin
                                // decide whether a value starts here
                                v[0] = 1'b0;
                                case (s.mode)
                                    M_TOP: begin
                                        if (s.seen && !i_streaming) begin
                                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_BYTE);
                                            s.err = 1'b1;
                                        end else begin
                                            if (s.seen)
                                                emit(r, n, K_EVENT, TK_DONE, 8'd0, s.lvl,
                                                     E_NONE);
                                            s.seen = 1'b1;
                                            v[0] = 1'b1;
                                        end
                                    end
                                    M_ARR_FIRST: begin
                                        if (c == "]") begin
                                            s.lvl = s.lvl - 1'b1;
                                            stk = {1'b0, stk[MAX_DEPTH-1:1]};
                                            emit(r, n, K_EVENT, TK_ARR_END, 8'd0, s.lvl,
                                                 E_NONE);
                                            s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                                        end else begin
                                            v[0] = 1'b1;
                                        end
                                    end
                                    M_VALUE: v[0] = 1'b1;
                                    M_AFTER: begin
                                        obj = stk[0];
                                        if (c == ",") begin
                                            s.mode = obj ? M_KEY : M_VALUE;
                                        end else if ((obj && c == "}") || (!obj && c == "]")) begin
                                            s.lvl = s.lvl - 1'b1;
                                            stk = {1'b0, stk[MAX_DEPTH-1:1]};
                                            emit(r, n, K_EVENT, obj ? TK_OBJ_END : TK_ARR_END,
                                                 8'd0, s.lvl, E_NONE);
                                            s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                                        end else begin
                                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl,
                                                 obj ? E_OBJECT : E_BYTE);
                                            s.err = 1'b1;
                                        end
                                    end
                                    M_OBJ_FIRST, M_KEY: begin
                                        if (c == "}" && s.mode == M_OBJ_FIRST) begin
                                            s.lvl = s.lvl - 1'b1;
                                            stk = {1'b0, stk[MAX_DEPTH-1:1]};
                                            emit(r, n, K_EVENT, TK_OBJ_END, 8'd0, s.lvl,
                                                 E_NONE);
                                            s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                                        end else if (c == "\"") begin
                                            s.mode = M_STR | M_KEY_BIT;
                                        end else begin
                                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl,
                                                 E_OBJECT);
                                            s.err = 1'b1;
                                        end
                                    end
                                    M_COLON: begin
                                        if (c == ":") begin
                                            s.mode = M_VALUE;
                                        end else begin
                                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl,
                                                 E_OBJECT);
                                            s.err = 1'b1;
                                        end
                                    end
                                    default: begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_BYTE);
                                        s.err = 1'b1;
                                    end
                                endcase
                                if (v[0]) begin
                                    if (c == "{" || c == "[") begin
                                        if (s.lvl >= LVL_W'(MAX_DEPTH)) begin
                                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl,
                                                 E_OVERFLOW);
                                            s.err = 1'b1;
                                        end else begin
                                            stk = {stk[MAX_DEPTH-2:0], c == "{"};
                                            s.lvl = s.lvl + 1'b1;
                                            emit(r, n, K_EVENT,
                                                 (c == "{") ? TK_OBJ_BEGIN : TK_ARR_BEGIN,
                                                 8'd0, s.lvl, E_NONE);
                                            s.mode = (c == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
                                        end
                                    end else if (c == "\"") begin
                                        s.mode = M_STR;
                                    end else if (c == "n" || c == "f" || c == "t") begin
                                        s.acc = (c == "n") ? 16'h0000 :
                                                (c == "f") ? 16'h0014 : 16'h0029;
                                        s.mode = M_LIT;
                                    end else if (c == "-" || dig) begin
                                        emit(r, n, K_BYTE, TK_NUMBER, c, s.lvl, E_NONE);
                                        s.mode = (c == "-") ? M_N_MINUS :
                                                 (c == "0") ? M_N_ZERO : M_N_INT;
                                    end else begin
                                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_BYTE);
                                        s.err = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            FN_END: begin
                if (!i_st.err) begin
                    if (s.mode >= M_STR) begin
                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl,
                             (s.mode[2:0] == S_UTF8) ? E_UTF8 : E_UNTERM);
                        s.err = 1'b1;
                    end else if (s.mode == M_LIT) begin
                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_LITERAL);
                        s.err = 1'b1;
                    end else if (s.mode == M_N_MINUS) begin
                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_BYTE);
                        s.err = 1'b1;
                    end else if (s.mode == M_N_FRAC0 || s.mode == M_N_EXP0 ||
                                 s.mode == M_N_EXPS) begin
                        emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_NUMBER);
                        s.err = 1'b1;
                    end else begin
                        if (s.mode >= M_N_ZERO) begin
                            emit(r, n, K_EVENT, TK_NUMBER, 8'd0, s.lvl, E_NONE);
                            s.mode = (s.lvl == '0) ? M_TOP : M_AFTER;
                        end
                        if (s.mode == M_TOP && s.seen) begin
                            emit(r, n, K_EVENT, TK_DONE, 8'd0, s.lvl, E_NONE);
                        end else begin
                            emit(r, n, K_ERROR, TK_NULL, 8'd0, s.lvl, E_EOF);
                            s.err = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_st = s;
        o_stk = stk;
        o_res = r;
        o_cnt = n;
    end

endmodule
`default_nettype wire

/* hdl/jst_outq.sv */
// Result register: holds the words caused by one input word and hands them
// out one per cycle while the output is not stalled. Depends on jst_pkg.
`default_nettype none
module jst_outq (
    input  var logic                      i_clk,
    input  var logic                      i_rst_n,
    input  var logic                      i_load,
    input  var jst_pkg::t_res_arr         i_res,
    input  var logic [jst_pkg::CNT_W-1:0] i_cnt,
    input  var logic [31:0]               i_line,
    input  var logic                      i_out_stall,
    output logic                          o_free,
    output logic                          o_out_valid,
    output jst_pkg::t_res                 o_res,
    output logic [31:0]                   o_line,
    output logic                          o_last
);
    import jst_pkg::*;

    t_res_arr         r_res;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_line;
    logic             take;

    assign take        = (r_cnt != '0) && !i_out_stall;
    assign o_free      = (r_cnt == '0) || (r_cnt == CNT_W'(1) && !i_out_stall);
    assign o_out_valid = (r_cnt != '0);
    assign o_res       = r_res[r_pos];
    assign o_line      = r_line;
    assign o_last      = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_pos <= '0;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
            r_pos <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res  <= i_res;
            r_line <= i_line;
        end
    end

endmodule
`default_nettype wire

/* hdl/json_stream_tokenizer.sv */
// Top level of the JSON stream tokenizer: parser state, nesting stack,
// config register and assertions. Depends on jst_pkg, jst_step, jst_outq.
//
//   channel | handshake                  | fields
//   in      | i_in_valid / o_in_stall    | i_func, i_data_byte
//   out     | o_out_valid / i_out_stall  | o_kind .. o_last
//   cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_data (streaming mode)
//
// One input word is taken per cycle while it causes at most one result and the
// output is not stalled; a word that causes k results stalls the input as the
// result register drains them. Results appear the cycle after the word is taken.
// Synchronous active-low reset clears state; line count resets to one.
// o_in_stall is high while the result register holds more than one word, or
// holds its last word and the output is stalled.
`default_nettype none
module json_stream_tokenizer (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_in_valid,
    output logic            o_in_stall,
    input  var logic [1:0]  i_func,
    input  var logic [7:0]  i_data_byte,
    output logic            o_out_valid,
    input  var logic        i_out_stall,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_token,
    output logic [7:0]      o_byte_value,
    output logic [6:0]      o_depth,
    output logic [31:0]     o_line,
    output logic [3:0]      o_error_code,
    output logic            o_last,
    input  var logic        i_cfg_valid,
    output logic            o_cfg_ready,
    input  var logic        i_cfg_data
);
    import jst_pkg::*;

    t_state               r_st;
    t_state               n_st;
    logic [MAX_DEPTH-1:0] r_stk;
    logic [MAX_DEPTH-1:0] n_stk;
    logic                 r_streaming;
    t_res_arr             step_res;
    logic [CNT_W-1:0]     step_cnt;
    logic                 free;
    logic                 accept;
    t_res                 cur;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !free;
    assign accept      = i_in_valid && free;

    jst_step u_step (
        .i_st        (r_st),
        .i_stk       (r_stk),
        .i_streaming (r_streaming),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_st        (n_st),
        .o_stk       (n_stk),
        .o_res       (step_res),
        .o_cnt       (step_cnt)
    );

    jst_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res       (step_res),
        .i_cnt       (step_cnt),
        .i_line      (r_st.line),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_res       (cur),
        .o_line      (o_line),
        .o_last      (o_last)
    );

    assign o_kind       = cur.kind;
    assign o_token      = cur.token;
    assign o_byte_value = cur.byte_value;
    assign o_depth      = cur.depth;
    assign o_error_code = cur.error_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '{mode: M_TOP, lvl: '0, acc: '0, hsur: '0, hold: '0,
                             left: '0, line: 32'd1, seen: 1'b0, err: 1'b0};
            r_streaming <= 1'b0;
        end else begin
            if (accept) r_st <= n_st;
            if (i_cfg_valid) r_streaming <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_stk <= n_stk;
    end

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == K_ERROR |-> o_last)
        else $error("error word not last of its group");

    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !i_out_stall |=> o_out_valid)
        else $error("result group cut short");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_depth <= 7'(MAX_DEPTH))
        else $error("depth beyond stack size");

    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_func == FN_RESTART |=> !o_out_valid && !r_st.err)
        else $error("restart produced results or kept error");

endmodule
`default_nettype wire
